@@ sv/workday_skipping_date_adder_unit_defines.svh @@
// assertion macros used by the date adder sequencer
// expects clk and rst_n to be visible where a macro is used
`ifndef WORKDAY_SKIPPING_DATE_ADDER_UNIT_DEFINES_SVH
`define WORKDAY_SKIPPING_DATE_ADDER_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define WSDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define WSDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  `WSDA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ sv/wsda_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and calendar functions of the date adder
// no dependencies
package wsda_pkg;

  localparam int WSDA_MAX_WORKING_DAYS = 4095;
  localparam int WD_W = 12;

  localparam logic [6:0] WEEKEND_MASK_RST = 7'd96;

  // reciprocals for exact constant division over the 15 bit range in use
  localparam logic [15:0] K100 = 16'd41944;  // ceil(2^22 / 100)
  localparam logic [15:0] K7   = 16'd37450;  // ceil(2^18 / 7)

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [2:0] WK_SAT = 3'd6;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [11:0] working_days;
  } in_item_t;

  typedef struct packed {
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [2:0]  end_weekday;
    logic        bad_date;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic ymod;
    logic wsum;
    logic wmod;
    logic wday;
    logic step;
    logic emit;
  } wsda_cmd_t;

  typedef struct packed {
    logic bad;
    logic walk_done;
  } wsda_sts_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      4'd2:                                         n = leap ? 5'd29 : 5'd28;
      default:                                      n = 5'd31;
    endcase
    return n;
  endfunction

  // (31 * mm) / 12 with march-based month numbering
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/workday_skipping_date_adder_unit.sv @@
`timescale 1ns / 1ps
// Workday-skipping date adder. Requests on in_* carry a start date and a
// count of working days; results on out_* carry the return date, its
// weekday and a flag for an invalid start date, which is echoed back.
// Both channels are valid/ready; one result per request, in order.
// cfg_we/cfg_wdata write the 7 bit weekend mask (bit n = weekday n,
// 0 = Sunday); reset sets Friday and Saturday. The user must write it
// only while the block is idle; the block itself does not enforce it.
// A request runs the setup steps (year modulo 400, date check and
// weekday sum, divide by 7, weekday residue), walks one calendar day per
// step up to 7 * MAX_WORKING_DAYS days added, ends the walk and then
// enters the output register. An invalid date skips divide, residue and walk.
// Throughput is one request at a time, set by the day-walk loop of the
// datapath. A new request is taken while a result waits in the output
// register; a stalled receiver holds the next result in the last phase.
// Reset (synchronous, rst_n low) empties the pipeline and restores the mask.
// Depends on wsda_pkg, wsda_ctrl and wsda_datapath.
module workday_skipping_date_adder_unit
  import wsda_pkg::*;
#(
  parameter int MAX_WORKING_DAYS = WSDA_MAX_WORKING_DAYS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  wsda_cmd_t cmd;
  wsda_sts_t sts;

  wsda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  wsda_datapath #(
    .MAX_WORKING_DAYS (MAX_WORKING_DAYS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data  (out_data)
  );

endmodule

@@ sv/wsda_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer of the date adder: handshakes, phase order and output valid
// depends on wsda_pkg and the assertion macro header
`include "workday_skipping_date_adder_unit_defines.svh"
module wsda_ctrl
  import wsda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output wsda_cmd_t cmd_o,
  input  wsda_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YMOD,
    S_WSUM,
    S_WMOD,
    S_WDAY,
    S_WALK,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd_o         = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_YMOD;
        end
      end
      S_YMOD: begin
        cmd_o.ymod = 1'b1;
        state_nxt  = S_WSUM;
      end
      S_WSUM: begin
        cmd_o.wsum = 1'b1;
        // an invalid start date is echoed without a walk
        state_nxt  = sts_i.bad ? S_OUT : S_WMOD;
      end
      S_WMOD: begin
        cmd_o.wmod = 1'b1;
        state_nxt  = S_WDAY;
      end
      S_WDAY: begin
        cmd_o.wday = 1'b1;
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.emit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WSDA_ASSERT(a_emit_into_free, cmd_o.emit |-> (!out_valid_r || out_ready), "result overwritten")
  `WSDA_ASSERT_NEXT(a_load_starts, in_valid && in_ready, state_r == S_YMOD, "request not started")
  `WSDA_ASSERT_NEXT(a_bad_skips, (state_r == S_WSUM) && sts_i.bad, state_r == S_OUT, "bad date walked")

endmodule

@@ sv/wsda_datapath.sv @@
`timescale 1ns / 1ps
// date adder datapath: weekday arithmetic, day walk and result register
// depends on wsda_pkg
module wsda_datapath
  import wsda_pkg::*;
#(
  parameter int MAX_WORKING_DAYS = WSDA_MAX_WORKING_DAYS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata,
  input  in_item_t  in_data,
  input  wsda_cmd_t cmd_i,
  output wsda_sts_t sts_o,
  output out_item_t out_data
);

  localparam int LW = $clog2(MAX_WORKING_DAYS + 1);
  localparam int SW = $clog2(7 * MAX_WORKING_DAYS + 1);
  localparam int CW = (LW > WD_W) ? LW : WD_W;
  localparam logic [SW-1:0] SPAN_LIMIT = SW'(7 * MAX_WORKING_DAYS);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_WORKING_DAYS);

  logic [6:0]    mask_r;
  logic [13:0]   y_r;
  logic [3:0]    m_r;
  logic [4:0]    d_r;
  logic [WD_W-1:0] wd_r;
  logic [14:0]   yy_r;
  logic [30:0]   prod_y_r, prod_yy_r;
  logic [8:0]    m400_r;
  logic [15:0]   sum_r;
  logic [31:0]   prod7_r;
  logic          bad_r;
  logic [2:0]    wk_r;
  logic [LW-1:0] left_r;
  logic [SW-1:0] span_r;
  out_item_t     out_r;

  logic [14:0]   yy_in;
  logic          a_in;
  logic [7:0]    q_y, q_yy;
  logic [13:0]   q7;
  logic          leap;
  logic [4:0]    dim;
  logic          bad_c;
  logic [CW-1:0] wd_ext;
  logic [LW-1:0] left_init;

  assign a_in  = (in_data.start_month == MON_JAN) || (in_data.start_month == MON_FEB);
  assign yy_in = 15'(in_data.start_year) + 15'd400 - 15'(a_in);

  assign q_y  = prod_y_r[29:22];
  assign q_yy = prod_yy_r[29:22];
  assign q7   = prod7_r[31:18];

  // leap from the year modulo 400
  assign leap = (m400_r[1:0] == 2'd0) && (m400_r != 9'd100) && (m400_r != 9'd200)
                && (m400_r != 9'd300);
  assign dim  = days_in(m_r, leap);

  assign bad_c = (m_r < MON_JAN) || (m_r > MON_DEC) || (d_r == 5'd0) || (d_r > dim);

  assign wd_ext    = CW'(wd_r);
  assign left_init = (wd_ext > MAX_C) ? LW'(MAX_C) : LW'(wd_ext);

  assign sts_o.bad       = bad_c;
  assign sts_o.walk_done = (left_r == '0) || (span_r == SPAN_LIMIT);
  assign out_data        = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= WEEKEND_MASK_RST;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      y_r       <= in_data.start_year;
      m_r       <= in_data.start_month;
      d_r       <= in_data.start_day;
      wd_r      <= in_data.working_days;
      yy_r      <= yy_in;
      prod_y_r  <= 31'(in_data.start_year) * 31'(K100);
      prod_yy_r <= 31'(yy_in) * 31'(K100);
    end
    if (cmd_i.ymod) begin
      m400_r <= 9'(y_r - 14'(q_y[7:2]) * 14'd400);
    end
    if (cmd_i.wsum) begin
      bad_r <= bad_c;
      sum_r <= 16'(d_r) + 16'(yy_r) + 16'(yy_r[14:2]) - 16'(q_yy) + 16'(q_yy[7:2])
               + 16'(month_offset(m_r));
    end
    if (cmd_i.wmod) begin
      prod7_r <= 32'(sum_r) * 32'(K7);
    end
    if (cmd_i.wday) begin
      wk_r   <= 3'(sum_r - 16'(q7) * 16'd7);
      left_r <= left_init;
      span_r <= '0;
    end
    if (cmd_i.step) begin
      if (!mask_r[wk_r]) begin
        left_r <= left_r - LW'(1);
      end
      span_r <= span_r + SW'(1);
      wk_r   <= (wk_r == WK_SAT) ? 3'd0 : wk_r + 3'd1;
      if (d_r == dim) begin
        d_r <= 5'd1;
        if (m_r == MON_DEC) begin
          m_r    <= MON_JAN;
          y_r    <= y_r + 14'd1;
          m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
        end else begin
          m_r <= m_r + 4'd1;
        end
      end else begin
        d_r <= d_r + 5'd1;
      end
    end
    if (cmd_i.emit) begin
      out_r.end_year    <= y_r;
      out_r.end_month   <= m_r;
      out_r.end_day     <= d_r;
      out_r.end_weekday <= bad_r ? 3'd0 : wk_r;
      out_r.bad_date    <= bad_r;
    end
  end

endmodule
